// ===== design/whs_pkg.sv =====
// shared types and constants for the weighted hop selector
package whs_pkg;

  // fixed field widths
  localparam int RATE_REG_W  = 16;
  localparam int NUM_RATES   = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int FRAC_W      = 16;
  localparam int TOTAL_W     = 24;
  localparam int HOP_IDX_W   = 8;
  localparam int HOP_CNT_W   = 9;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;
  localparam int IN_USER_W   = 2;

  localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [RATE_REG_W-1:0] RATE_RESET = RATE_REG_W'(256);

  // operation codes carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SELECT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    append;
    logic    clear;
    logic    res_set;
    status_t res_status;
    logic    scan_start;
    logic    scan_step;
    logic    res_found;
    logic    out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic list_empty;
    logic list_full;
    logic hit;
    logic last;
  } sts_t;

endpackage

// ===== design/whs_ctrl.sv =====
// controller state machine: sequences append, clear and the select scan
module whs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic [whs_pkg::OP_W-1:0]     in_op,
  output logic                         in_tready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  whs_pkg::sts_t                sts,
  output whs_pkg::cmd_t                cmd
);
  import whs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (op_t'(in_op))
            OP_APPEND: begin
              cmd.res_set = 1'b1;
              if (sts.list_full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.append     = 1'b1;
                cmd.res_status = ST_OK;
              end
              state_nxt = S_DONE;
            end
            OP_SELECT: begin
              if (sts.list_empty) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            OP_CLEAR: begin
              cmd.clear      = 1'b1;
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_DONE;
            end
            default: begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.res_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOMATCH;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/whs_dp.sv =====
// datapath: rate registers, hop memory, running total, draw and prefix scan
module whs_dp #(
  parameter int MAX_HOPS  = 256,
  parameter int RATE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [whs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [whs_pkg::RATE_REG_W-1:0]    cfg_wdata,
  input  logic [whs_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic [whs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  whs_pkg::cmd_t                     cmd,
  output whs_pkg::sts_t                     sts
);
  import whs_pkg::*;

  localparam int IDX_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int LEN_W = $clog2(MAX_HOPS + 1);
  localparam int RW    = (RATE_BITS < RATE_REG_W) ? RATE_BITS : RATE_REG_W;
  localparam int SUM_W = RW + LEN_W;
  localparam int CMP_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
  localparam int PROD_W = FRAC_W + TOTAL_W;

  // input fields
  logic              in_term;
  logic              in_dir;
  logic [FRAC_W-1:0] in_frac;

  assign in_term = in_tdata[0];
  assign in_dir  = in_tdata[1];
  assign in_frac = in_tdata[FRAC_W+1:2];

  // state
  logic [RATE_REG_W-1:0] rate_cfg_r [NUM_RATES];
  logic [LEN_W-1:0]      length_r, length_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic [1:0]            hop_mem [MAX_HOPS];

  // scan registers
  logic [1:0]            q_r;
  logic [TOTAL_W-1:0]    draw_r;
  logic [SUM_W-1:0]      sum_r;
  logic [IDX_W-1:0]      scan_idx_r;
  logic [IDX_W-1:0]      rd_addr;

  // result registers
  status_t               res_status_r;
  logic [IDX_W-1:0]      res_idx_r;
  logic                  res_term_r;
  logic                  res_dir_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [RW-1:0]         app_rate;
  logic [RW-1:0]         scan_rate;
  logic [TOTAL_W:0]      total_sum;
  logic [SUM_W-1:0]      sum_nxt;
  logic [PROD_W-1:0]     prod;

  // rate lookup: register index is terminus then direction
  assign app_rate  = rate_cfg_r[{in_term, in_dir}][RW-1:0];
  assign scan_rate = rate_cfg_r[{q_r[0], q_r[1]}][RW-1:0];

  // saturating running total
  assign total_sum = {1'b0, total_r} + (TOTAL_W+1)'(app_rate);

  always_comb begin
    length_nxt = length_r;
    total_nxt  = total_r;
    if (cmd.clear) begin
      length_nxt = '0;
      total_nxt  = '0;
    end else if (cmd.append) begin
      length_nxt = length_r + LEN_W'(1);
      total_nxt  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end
  end

  // status toward controller
  assign sum_nxt        = sum_r + SUM_W'(scan_rate);
  assign sts.list_empty = (length_r == '0);
  assign sts.list_full  = (length_r == LEN_W'(MAX_HOPS));
  assign sts.hit        = CMP_W'(sum_nxt) > CMP_W'(draw_r);
  assign sts.last       = (LEN_W'(scan_idx_r) + LEN_W'(1)) == length_r;

  // draw = fraction scaled by total
  assign prod    = PROD_W'(in_frac) * PROD_W'(total_r);
  assign rd_addr = cmd.scan_start ? '0 : scan_idx_r + IDX_W'(1);

  // configuration and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RATES; i++) begin
        rate_cfg_r[i] <= RATE_RESET;
      end
      length_r <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we) begin
        rate_cfg_r[cfg_addr] <= cfg_wdata;
      end
      length_r <= length_nxt;
      total_r  <= total_nxt;
    end
  end

  // hop memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      hop_mem[length_r[IDX_W-1:0]] <= {in_dir, in_term};
    end
    if (cmd.scan_start || cmd.scan_step) begin
      q_r <= hop_mem[rd_addr];
    end
  end

  // scan pointer, prefix sum and draw
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      draw_r     <= prod[PROD_W-1:FRAC_W];
      sum_r      <= '0;
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      sum_r      <= sum_nxt;
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.res_found) begin
      res_status_r <= ST_OK;
      res_idx_r    <= scan_idx_r;
      res_term_r   <= q_r[0];
      res_dir_r    <= q_r[1];
    end else if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_idx_r    <= '0;
      res_term_r   <= 1'b0;
      res_dir_r    <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_DATA_W'({HOP_CNT_W'(length_r), total_r, res_dir_r, res_term_r,
                                 HOP_IDX_W'(res_idx_r), res_status_r});
    end
  end

  assign out_tdata = out_data_r;

endmodule

// ===== design/weighted_hop_selector.sv =====
// top level of the weighted hop selector (roulette wheel choice over a hop list)
//
//  channel  group            fields (low bit up)
//  input    in_t*            tuser: op; tdata: terminus, direction, random_fraction
//  result   out_t*           tdata: status, hop_index, selected_terminus,
//                            selected_direction, total_rate, hop_count
//  config   cfg_we/addr/...  addr 0..3: head fwd, head bwd, tail fwd, tail bwd rate
//
// append, clear and unused op: the accept leads to the done state, then back to idle once the output is free.
// select: the accept leads to the scan state, which steps hop by hop until a hit or the last hop, then to done; the
// prefix scan reads the hop memory one entry per cycle through its single read port.
// reset (rst_n low, synchronous) empties the list, zeroes the total and sets all
// rates to 1.0; the hop memory is not cleared.
// one item is in flight at a time; a result waits in the output register while
// out_tready is low, and the next result waits until that transfer completes.
module weighted_hop_selector #(
  parameter int MAX_HOPS  = 256,
  parameter int RATE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [whs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [whs_pkg::RATE_REG_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // terminus, direction, random_fraction, zero pad
  input  logic [whs_pkg::IN_DATA_W-1:0]    in_tdata,
  // op
  input  logic [whs_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, hop_index, selected_terminus, selected_direction, total_rate,
  // hop_count, zero pad
  output logic [whs_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import whs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  whs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath
  whs_dp #(
    .MAX_HOPS  (MAX_HOPS),
    .RATE_BITS (RATE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/whs_checker.sv =====
// port-level assertions for the weighted hop selector, bound to the top level
module whs_checker #(
  parameter int MAX_HOPS = 256
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [whs_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import whs_pkg::*;

  logic [STATUS_W-1:0]  st;
  logic [TOTAL_W-1:0]   total;
  logic [HOP_CNT_W-1:0] count;

  assign st    = out_tdata[1:0];
  assign total = out_tdata[35:12];
  assign count = out_tdata[44:36];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // full list reports the maximum count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL |-> count == HOP_CNT_W'(MAX_HOPS))
    else $error("full status with wrong hop count");

  // empty list has no hops and no total
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> count == '0 && total == '0)
    else $error("empty status with hops or rate listed");

  // an error result carries no selection
  a_err_nosel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> out_tdata[11:2] == '0)
    else $error("error result with selection fields set");

endmodule

bind weighted_hop_selector whs_checker #(.MAX_HOPS(MAX_HOPS)) u_whs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/weighted_hop_selector_tb.sv =====
// testbench for the weighted hop selector: directed and random op streams checked by a predictor
module weighted_hop_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import whs_pkg::*;

  localparam int LIST_DEPTH       = 256;
  localparam int LIST_RATE_BITS   = 16;
  localparam int DRAIN_CYCLES     = LIST_DEPTH + 40;
  localparam int LONG_HOLD_CYCLES = 400;

  // rate bank register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD_FWD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD_BWD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL_FWD = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL_BWD = 2'd3;

  // one result transfer, split into its fields
  typedef struct {
    status_t             status;
    logic [HOP_IDX_W-1:0] hop_index;
    logic                terminus;
    logic                direction;
    logic [TOTAL_W-1:0]  total_rate;
    logic [HOP_CNT_W-1:0] hop_count;
  } pick_t;

  // hop list predictor and store of pending picks
  class hop_pick_tracker;
    logic [RATE_REG_W-1:0] rate [NUM_RATES];
    logic [1:0]            hops [$];  // bit0 terminus, bit1 direction
    logic [TOTAL_W-1:0]    total;
    pick_t                 pending_picks [$];
    int                    errors;

    function new();
      foreach (rate[k]) rate[k] = RATE_RESET;
      total  = '0;
      errors = 0;
    endfunction

    function void set_rate(logic [CFG_ADDR_W-1:0] sel, logic [RATE_REG_W-1:0] value);
      rate[sel] = value;
    endfunction

    function logic [63:0] rate_of(logic [1:0] code);
      logic [RATE_REG_W-1:0] r;
      r = rate[{code[0], code[1]}];
      return 64'(r) & ((64'd1 << LIST_RATE_BITS) - 64'd1);
    endfunction

    // work out the pick that an accepted request must produce
    function void note_request(op_t op, logic term, logic dir, logic [FRAC_W-1:0] frac);
      pick_t       want;
      logic [63:0] draw;
      logic [63:0] sum;
      logic [63:0] grown;
      want.status    = ST_OK;
      want.hop_index = '0;
      want.terminus  = 1'b0;
      want.direction = 1'b0;
      case (op)
        OP_APPEND: begin
          if (hops.size() >= LIST_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            hops.insert(hops.size(), {dir, term});
            grown = 64'(total) + rate_of({dir, term});
            total = (grown > 64'(TOTAL_MAX)) ? TOTAL_MAX : grown[TOTAL_W-1:0];
          end
        end
        OP_SELECT: begin
          if (hops.size() == 0) begin
            want.status = ST_EMPTY;
          end else begin
            // first hop whose prefix sum passes the scaled draw
            draw = (64'(frac) * 64'(total)) >> FRAC_W;
            sum  = '0;
            want.status = ST_NOMATCH;
            for (int i = 0; i < hops.size(); i++) begin
              sum += rate_of(hops[i]);
              if (sum > draw) begin
                want.status    = ST_OK;
                want.hop_index = HOP_IDX_W'(i);
                want.terminus  = hops[i][0];
                want.direction = hops[i][1];
                break;
              end
            end
          end
        end
        OP_CLEAR: begin
          hops.delete();
          total = '0;
        end
        default: begin
        end
      endcase
      want.total_rate = total;
      want.hop_count  = HOP_CNT_W'(hops.size());
      pending_picks.insert(pending_picks.size(), want);
    endfunction

    // compare a result transfer with the oldest pending pick
    function void check_pick(logic [OUT_DATA_W-1:0] d);
      pick_t got;
      pick_t want;
      got.status     = status_t'(d[1:0]);
      got.hop_index  = d[9:2];
      got.terminus   = d[10];
      got.direction  = d[11];
      got.total_rate = d[35:12];
      got.hop_count  = d[44:36];
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = pending_picks.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.hop_index !== want.hop_index) begin
        $display("%0t: hop_index expected %0d actual %0d", $time, want.hop_index,
                 got.hop_index);
        errors++;
      end
      if (got.terminus !== want.terminus) begin
        $display("%0t: terminus expected %b actual %b", $time, want.terminus, got.terminus);
        errors++;
      end
      if (got.direction !== want.direction) begin
        $display("%0t: direction expected %b actual %b", $time, want.direction,
                 got.direction);
        errors++;
      end
      if (got.total_rate !== want.total_rate) begin
        $display("%0t: total_rate expected %h actual %h", $time, want.total_rate,
                 got.total_rate);
        errors++;
      end
      if (got.hop_count !== want.hop_count) begin
        $display("%0t: hop_count expected %0d actual %0d", $time, want.hop_count,
                 got.hop_count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [RATE_REG_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  bit idle_on   = 1'b1;
  bit long_hold = 1'b0;

  hop_pick_tracker picks = new();

  weighted_hop_selector #(
    .MAX_HOPS (LIST_DEPTH),
    .RATE_BITS(LIST_RATE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) picks.check_pick(out_tdata);
  end

  // result side ready, with random stalls and one long hold-off
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one request and wait for its transfer
  task automatic send_item(op_t op, logic term, logic dir, logic [FRAC_W-1:0] frac);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - FRAC_W - 2){1'b0}}, frac, dir, term};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    picks.note_request(op, term, dir, frac);
  endtask

  function automatic logic [FRAC_W-1:0] pick_fraction();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return FRAC_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // mostly appends and selects, with some clears and unused ops
  task automatic send_random();
    int   r;
    op_t  op;
    r = $urandom_range(0, 99);
    if (r < 45)      op = OP_APPEND;
    else if (r < 85) op = OP_SELECT;
    else if (r < 93) op = OP_CLEAR;
    else             op = OP_NONE;
    send_item(op, 1'($urandom), 1'($urandom), pick_fraction());
  endtask

  // drop valid and let every pending pick arrive
  task automatic settle();
    in_tvalid <= 1'b0;
    while (picks.pending_picks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_ADDR_W-1:0] sel, logic [RATE_REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    picks.set_rate(sel, value);
  endtask

  // load the whole rate bank while idle
  task automatic write_rates(logic [RATE_REG_W-1:0] hf, logic [RATE_REG_W-1:0] hb,
                             logic [RATE_REG_W-1:0] tf, logic [RATE_REG_W-1:0] tb);
    put_reg(REG_HEAD_FWD, hf);
    put_reg(REG_HEAD_BWD, hb);
    put_reg(REG_TAIL_FWD, tf);
    put_reg(REG_TAIL_BWD, tb);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RATE_REG_W-1:0] pick_rate();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return RATE_REG_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, unused op, every hop kind, draw extremes, clear
    send_item(OP_SELECT, 1'b1, 1'b1, 16'h1234);
    send_item(OP_NONE, 1'b1, 1'b1, 16'hFFFF);
    send_item(OP_APPEND, 1'b0, 1'b0, 16'h0000);
    send_item(OP_APPEND, 1'b0, 1'b1, 16'hFFFF);
    send_item(OP_APPEND, 1'b1, 1'b0, 16'h0000);
    send_item(OP_APPEND, 1'b1, 1'b1, 16'hFFFF);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_item(OP_SELECT, 1'b1, 1'b1, 16'hFFFF);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'h8000);
    send_item(OP_NONE, 1'b0, 1'b1, 16'h5555);
    send_item(OP_CLEAR, 1'b1, 1'b0, 16'hAAAA);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_item(OP_APPEND, 1'b1, 1'b0, 16'h0000);
    send_item(OP_APPEND, 1'b0, 1'b1, 16'h0000);
    settle();

    // all rates zero: nothing can pass the draw
    write_rates('0, '0, '0, '0);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_item(OP_APPEND, 1'b0, 1'b0, 16'hFFFF);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'hFFFF);
    settle();

    // rates changed under a non-empty list
    write_rates('1, '1, '1, '1);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'hFFFF);
    send_item(OP_SELECT, 1'b0, 1'b0, 16'h0000);
    send_item(OP_APPEND, 1'b1, 1'b1, 16'h0000);
    send_item(OP_SELECT, 1'b1, 1'b1, 16'hFFFF);
    settle();

    // random phases, each with a new rate bank
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      write_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
      repeat (14) send_random();
      settle();
    end

    // fill the list to capacity while the result side holds off
    idle_on = 1'b1;
    write_rates('1, '1, '1, '1);
    long_hold = 1'b1;
    send_item(OP_CLEAR, 1'b0, 1'b0, 16'h0000);
    repeat (LIST_DEPTH) send_item(OP_APPEND, 1'($urandom), 1'($urandom), pick_fraction());
    repeat (3) send_item(OP_APPEND, 1'($urandom), 1'($urandom), pick_fraction());
    send_item(OP_SELECT, 1'b0, 1'b0, 16'hFFFF);
    send_item(OP_SELECT, 1'b1, 1'b1, 16'h0000);
    repeat (8) send_item(OP_SELECT, 1'($urandom), 1'($urandom), pick_fraction());
    settle();

    // new rates against the full list
    write_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
    repeat (10) send_item(OP_SELECT, 1'($urandom), 1'($urandom), pick_fraction());
    settle();

    // closing stretch at full rate
    idle_on = 1'b0;
    write_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
    repeat (40) send_random();
    in_tvalid <= 1'b0;
    while (picks.pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (picks.errors == 0 && picks.pending_picks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
